// File: rtl/core/acf_pkg.sv
package acf_pkg;

   // field widths
   localparam int SampleW = 16;
   localparam int StampW  = 32;
   localparam int AngleW  = 16;
   localparam int AccW    = 32;
   localparam int WeightW = 16;
   localparam int DtW     = 16;
   localparam int CsrIdxW = 2;

   // rotation steps of the vectoring loop, capped at the arctangent table length
   localparam int CordicSteps = 16;
   localparam int AtanLen     = 24;
   localparam int RotSteps    = (CordicSteps < AtanLen) ? CordicSteps : AtanLen;
   localparam int StepW       = $clog2(AtanLen);

   // one result bit of the root per step
   localparam int RootBits = 28;

   // angle constants in 2^-16 degree
   localparam logic signed [AccW-1:0] HalfTurn = 32'sd11796480;
   localparam logic signed [AccW-1:0] FullTurn = 32'sd23592960;

   // degrees per rad/s-microsecond, scaled by 2^32 * 16
   localparam int RateScaleW = 22;
   localparam logic [RateScaleW-1:0] RateScale = 22'd3937336;

   localparam logic [WeightW-1:0] WeightReset = 16'd64225;

   localparam logic OpSeed   = 1'b0;
   localparam logic OpUpdate = 1'b1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_WEIGHT   = 2'd0,
      CSR_OFFSET_X = 2'd1,
      CSR_OFFSET_Y = 2'd2,
      CSR_OFFSET_Z = 2'd3
   } csr_index_type;

   // arctangent of 2^-i in 2^-16 degree
   function automatic logic signed [AccW-1:0] atan_entry(input logic [StepW-1:0] idx);
      logic signed [AccW-1:0] v;
      case (idx)
         5'd0:    v = 32'sd2949120;
         5'd1:    v = 32'sd1740967;
         5'd2:    v = 32'sd919879;
         5'd3:    v = 32'sd466945;
         5'd4:    v = 32'sd234379;
         5'd5:    v = 32'sd117304;
         5'd6:    v = 32'sd58666;
         5'd7:    v = 32'sd29335;
         5'd8:    v = 32'sd14668;
         5'd9:    v = 32'sd7334;
         5'd10:   v = 32'sd3667;
         5'd11:   v = 32'sd1833;
         5'd12:   v = 32'sd917;
         5'd13:   v = 32'sd458;
         5'd14:   v = 32'sd229;
         5'd15:   v = 32'sd115;
         5'd16:   v = 32'sd57;
         5'd17:   v = 32'sd29;
         5'd18:   v = 32'sd14;
         5'd19:   v = 32'sd7;
         5'd20:   v = 32'sd4;
         5'd21:   v = 32'sd2;
         5'd22:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // fold an angle back into one half turn either side of zero
   function automatic logic signed [AccW-1:0] wrap_angle(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] r;
      if (a > HalfTurn) begin
         r = a - FullTurn;
      end else if (a < -HalfTurn) begin
         r = a + FullTurn;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // round half up to 1/128 degree
   function automatic logic signed [AngleW-1:0] to_out(input logic signed [AccW-1:0] a);
      logic signed [AccW-1:0] s;
      s = a + 32'sd256;
      return s[24:9];
   endfunction

endpackage

// File: rtl/core/acf_tilt.sv
module acf_tilt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [acf_pkg::SampleW:0]    num,
   input  logic signed [acf_pkg::SampleW-1:0]  side_a,
   input  logic signed [acf_pkg::SampleW-1:0]  side_b,
   output logic                                valid,
   output logic signed [acf_pkg::AccW-1:0]     angle
);
   import acf_pkg::*;

   typedef enum logic [2:0] {T_IDLE, T_SQA, T_SQB, T_ROOT, T_ROT} tilt_state_type;

   tilt_state_type state_ff;
   logic                          valid_ff;
   logic signed [SampleW-1:0]     a_ff, b_ff;
   logic signed [SampleW:0]       num_ff;
   logic [31:0]                   sq_ff;
   logic [55:0]                   rad_ff;
   logic [30:0]                   rem_ff;
   logic [RootBits-1:0]           root_ff;
   logic [StepW-1:0]              cnt_ff;
   logic signed [AccW-1:0]        x_ff, y_ff, z_ff;

   logic signed [SampleW-1:0]     mul_op;
   logic signed [31:0]            sq_prod;
   logic [30:0]                   rem_sh;
   logic [30:0]                   trial;
   logic                          take;
   logic [RootBits-1:0]           root_in;
   logic signed [AccW-1:0]        xs, ys, tab;

   // one squarer, shared by both sides
   assign mul_op  = (state_ff == T_SQA) ? a_ff : b_ff;
   assign sq_prod = mul_op * mul_op;

   // root: bring in two radicand bits, try one result bit
   assign rem_sh  = {rem_ff[28:0], rad_ff[55:54]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign take    = (rem_sh >= trial);
   assign root_in = {root_ff[RootBits-2:0], take};

   // rotation step
   assign xs  = x_ff >>> cnt_ff;
   assign ys  = y_ff >>> cnt_ff;
   assign tab = atan_entry(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            T_IDLE: begin
               if (start) begin
                  a_ff     <= side_a;
                  b_ff     <= side_b;
                  num_ff   <= num;
                  valid_ff <= 1'b0;
                  state_ff <= T_SQA;
               end
            end
            T_SQA: begin
               sq_ff    <= $unsigned(sq_prod);
               state_ff <= T_SQB;
            end
            T_SQB: begin
               rad_ff   <= {sq_ff + $unsigned(sq_prod), 24'd0};
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= T_ROOT;
            end
            T_ROOT: begin
               rem_ff  <= take ? (rem_sh - trial) : rem_sh;
               root_ff <= root_in;
               rad_ff  <= {rad_ff[53:0], 2'b00};
               if (cnt_ff == StepW'(RootBits - 1)) begin
                  cnt_ff <= '0;
                  x_ff   <= {{(AccW-RootBits){1'b0}}, root_in};
                  y_ff   <= {{(AccW-SampleW-13){num_ff[SampleW]}}, num_ff, 12'd0};
                  z_ff   <= '0;
                  // zero vector: no angle to find
                  if (root_in == '0 && num_ff == '0) begin
                     valid_ff <= 1'b1;
                     state_ff <= T_IDLE;
                  end else begin
                     state_ff <= T_ROT;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            T_ROT: begin
               if (!y_ff[AccW-1]) begin
                  x_ff <= x_ff + ys;
                  y_ff <= y_ff - xs;
                  z_ff <= z_ff + tab;
               end else begin
                  x_ff <= x_ff - ys;
                  y_ff <= y_ff + xs;
                  z_ff <= z_ff - tab;
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == StepW'(RotSteps - 1)) begin
                  valid_ff <= 1'b1;
                  state_ff <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign valid = valid_ff;
   assign angle = z_ff;

endmodule

// File: rtl/core/acf_gyro.sv
module acf_gyro (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [acf_pkg::SampleW-1:0]  rate,
   input  logic signed [acf_pkg::SampleW-1:0]  offset,
   input  logic [acf_pkg::DtW-1:0]             elapsed,
   output logic                                valid,
   output logic signed [acf_pkg::AccW-1:0]     delta
);
   import acf_pkg::*;

   typedef enum logic [1:0] {G_IDLE, G_DT, G_SCALE, G_ROUND} gyro_state_type;

   gyro_state_type state_ff;
   logic                     valid_ff;
   logic signed [32:0]       mc1_ff, acc1_ff;
   logic [DtW-1:0]           dt_ff;
   logic signed [55:0]       mc2_ff, acc2_ff;
   logic [RateScaleW-1:0]    rs_ff;
   logic [4:0]               cnt_ff;
   logic signed [AccW-1:0]   delta_ff;

   logic signed [SampleW:0]  diff;
   logic signed [32:0]       acc1_in;
   logic signed [55:0]       rounded;

   assign diff    = {rate[SampleW-1], rate} - {offset[SampleW-1], offset};
   assign acc1_in = dt_ff[0] ? (acc1_ff + mc1_ff) : acc1_ff;
   assign rounded = acc2_ff + 56'sd2147483648;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            G_IDLE: begin
               if (start) begin
                  mc1_ff   <= {{16{diff[SampleW]}}, diff};
                  acc1_ff  <= '0;
                  dt_ff    <= elapsed;
                  cnt_ff   <= '0;
                  valid_ff <= 1'b0;
                  state_ff <= G_DT;
               end
            end
            // rate times elapsed time, one time bit a cycle
            G_DT: begin
               acc1_ff <= acc1_in;
               mc1_ff  <= mc1_ff <<< 1;
               dt_ff   <= dt_ff >> 1;
               if (cnt_ff == 5'(DtW - 1)) begin
                  mc2_ff   <= {{23{acc1_in[32]}}, acc1_in};
                  acc2_ff  <= '0;
                  rs_ff    <= RateScale;
                  cnt_ff   <= '0;
                  state_ff <= G_SCALE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            // scale to angle, one scale bit a cycle
            G_SCALE: begin
               if (rs_ff[0]) begin
                  acc2_ff <= acc2_ff + mc2_ff;
               end
               mc2_ff <= mc2_ff <<< 1;
               rs_ff  <= rs_ff >> 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(RateScaleW - 1)) begin
                  state_ff <= G_ROUND;
               end
            end
            G_ROUND: begin
               delta_ff <= {{8{rounded[55]}}, rounded[55:32]};
               valid_ff <= 1'b1;
               state_ff <= G_IDLE;
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign valid = valid_ff;
   assign delta = delta_ff;

endmodule

// File: rtl/core/acf_blend.sv
module acf_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [acf_pkg::AccW-1:0]    gyro,
   input  logic signed [acf_pkg::AccW-1:0]    tilt,
   input  logic [acf_pkg::WeightW-1:0]        weight,
   output logic                               valid,
   output logic signed [acf_pkg::AccW-1:0]    angle
);
   import acf_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_FIN} blend_state_type;

   blend_state_type state_ff;
   logic                    valid_ff;
   logic signed [49:0]      mc_ff, acc_ff;
   logic [WeightW-1:0]      w_ff;
   logic [4:0]              cnt_ff;
   logic signed [AccW-1:0]  angle_ff;

   logic signed [AccW:0]    diff;

   // t + w * (g - t), rounded, over one weight bit a cycle
   assign diff = {gyro[AccW-1], gyro} - {tilt[AccW-1], tilt};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (start) begin
                  mc_ff    <= {{17{diff[AccW]}}, diff};
                  acc_ff   <= {{2{tilt[AccW-1]}}, tilt, 16'h8000};
                  w_ff     <= weight;
                  cnt_ff   <= '0;
                  valid_ff <= 1'b0;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               if (w_ff[0]) begin
                  acc_ff <= acc_ff + mc_ff;
               end
               mc_ff  <= mc_ff <<< 1;
               w_ff   <= w_ff >> 1;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(WeightW - 1)) begin
                  state_ff <= B_FIN;
               end
            end
            B_FIN: begin
               angle_ff <= wrap_angle(acc_ff[47:16]);
               valid_ff <= 1'b1;
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign valid = valid_ff;
   assign angle = angle_ff;

endmodule

// File: rtl/core/attitude_complementary_filter_top.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_ready | operation, accel x/y/z, rate x/y/z, stamp
// rsp     | out       | rsp_valid/rsp_ready | pitch, roll, yaw in 1/128 degree
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One word at a time. The tilt lanes (28 root steps plus 16 rotation steps) set
// the time from acceptance to result for a seed; an update adds the 16-step
// weight multiply of the blend.
// Reset clears the angles, the time stamp and the registers to their defaults.
// A result waiting on rsp_ready holds the next word at the output stage only.
module attitude_complementary_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [acf_pkg::SampleW-1:0]  req_accel_x,
   input  logic signed [acf_pkg::SampleW-1:0]  req_accel_y,
   input  logic signed [acf_pkg::SampleW-1:0]  req_accel_z,
   input  logic signed [acf_pkg::SampleW-1:0]  req_rate_x,
   input  logic signed [acf_pkg::SampleW-1:0]  req_rate_y,
   input  logic signed [acf_pkg::SampleW-1:0]  req_rate_z,
   input  logic [acf_pkg::StampW-1:0]          req_stamp_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [acf_pkg::AngleW-1:0]   rsp_pitch_deg,
   output logic signed [acf_pkg::AngleW-1:0]   rsp_roll_deg,
   output logic signed [acf_pkg::AngleW-1:0]   rsp_yaw_deg,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acf_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [acf_pkg::WeightW-1:0]         csr_data
);
   import acf_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_BLEND, S_SEND} top_state_type;

   top_state_type state_ff;
   logic                      op_ff;
   logic signed [AccW-1:0]    pitch_ff, roll_ff, yaw_ff;
   logic [StampW-1:0]         last_stamp_ff;
   logic [WeightW-1:0]        weight_ff;
   logic signed [SampleW-1:0] off_x_ff, off_y_ff, off_z_ff;
   logic                      rsp_valid_ff;
   logic signed [AngleW-1:0]  rsp_pitch_ff, rsp_roll_ff, rsp_yaw_ff;

   logic                      accept;
   logic [StampW-1:0]         elapsed_raw;
   logic [DtW-1:0]            elapsed;
   logic signed [SampleW:0]   num_pitch, num_roll;
   logic                      tp_valid, tr_valid, gx_valid, gy_valid, gz_valid;
   logic signed [AccW-1:0]    tp_angle, tr_angle, dx, dy, dz;
   logic                      all_done, blend_start, out_free;
   logic                      bp_valid, br_valid;
   logic signed [AccW-1:0]    bp_angle, br_angle;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;

   // elapsed time, saturated
   assign elapsed_raw = req_stamp_us - last_stamp_ff;
   assign elapsed     = (|elapsed_raw[StampW-1:DtW]) ? {DtW{1'b1}} : elapsed_raw[DtW-1:0];

   assign num_pitch = -{req_accel_x[SampleW-1], req_accel_x};
   assign num_roll  = {req_accel_y[SampleW-1], req_accel_y};

   acf_tilt u_tilt_pitch (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .num    (num_pitch),
      .side_a (req_accel_y),
      .side_b (req_accel_z),
      .valid  (tp_valid),
      .angle  (tp_angle)
   );

   acf_tilt u_tilt_roll (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .num    (num_roll),
      .side_a (req_accel_x),
      .side_b (req_accel_z),
      .valid  (tr_valid),
      .angle  (tr_angle)
   );

   acf_gyro u_gyro_x (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .rate    (req_rate_x),
      .offset  (off_x_ff),
      .elapsed (elapsed),
      .valid   (gx_valid),
      .delta   (dx)
   );

   acf_gyro u_gyro_y (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .rate    (req_rate_y),
      .offset  (off_y_ff),
      .elapsed (elapsed),
      .valid   (gy_valid),
      .delta   (dy)
   );

   acf_gyro u_gyro_z (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .rate    (req_rate_z),
      .offset  (off_z_ff),
      .elapsed (elapsed),
      .valid   (gz_valid),
      .delta   (dz)
   );

   assign all_done    = tp_valid && tr_valid && gx_valid && gy_valid && gz_valid;
   assign blend_start = (state_ff == S_RUN) && all_done && (op_ff == OpUpdate);

   acf_blend u_blend_pitch (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .gyro   (pitch_ff + dy),
      .tilt   (tp_angle),
      .weight (weight_ff),
      .valid  (bp_valid),
      .angle  (bp_angle)
   );

   acf_blend u_blend_roll (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .gyro   (roll_ff + dx),
      .tilt   (tr_angle),
      .weight (weight_ff),
      .valid  (br_valid),
      .angle  (br_angle)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequence one word and hold the output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pitch_ff      <= '0;
         roll_ff       <= '0;
         yaw_ff        <= '0;
         last_stamp_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_SEND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff         <= req_operation;
                  last_stamp_ff <= req_stamp_us;
                  state_ff      <= S_RUN;
               end
            end
            S_RUN: begin
               if (all_done) begin
                  if (op_ff == OpSeed) begin
                     pitch_ff <= tp_angle;
                     roll_ff  <= tr_angle;
                     state_ff <= S_SEND;
                  end else begin
                     yaw_ff   <= wrap_angle(yaw_ff + dz);
                     state_ff <= S_BLEND;
                  end
               end
            end
            S_BLEND: begin
               if (bp_valid && br_valid) begin
                  pitch_ff <= bp_angle;
                  roll_ff  <= br_angle;
                  state_ff <= S_SEND;
               end
            end
            S_SEND: begin
               if (out_free) begin
                  rsp_pitch_ff <= to_out(pitch_ff);
                  rsp_roll_ff  <= to_out(roll_ff);
                  rsp_yaw_ff   <= to_out(yaw_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WeightReset;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         off_z_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WEIGHT:   weight_ff <= csr_data;
            CSR_OFFSET_X: off_x_ff  <= $signed(csr_data);
            CSR_OFFSET_Y: off_y_ff  <= $signed(csr_data);
            CSR_OFFSET_Z: off_z_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;
   assign rsp_roll_deg  = rsp_roll_ff;
   assign rsp_yaw_deg   = rsp_yaw_ff;

endmodule

// File: rtl/core/acf_checker.sv
module acf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [acf_pkg::AngleW-1:0]   rsp_pitch_deg,
   input logic signed [acf_pkg::AngleW-1:0]   rsp_roll_deg,
   input logic signed [acf_pkg::AngleW-1:0]   rsp_yaw_deg
);
   import acf_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_deg)
         && $stable(rsp_roll_deg) && $stable(rsp_yaw_deg))
      else $error("result word changed while stalled");

   // one word in flight: busy straight after acceptance
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // angles stay within a half turn
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_deg >= -16'sd23040 && rsp_pitch_deg <= 16'sd23040
         && rsp_roll_deg >= -16'sd23040 && rsp_roll_deg <= 16'sd23040
         && rsp_yaw_deg >= -16'sd23040 && rsp_yaw_deg <= 16'sd23040)
      else $error("angle out of range");

   // drop results on reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind attitude_complementary_filter_top acf_checker u_acf_checker (.*);
